// File: hw/rtl/tssf_pkg.sv
// Package for the triangle span fill core: widths, commands, controller states.
// No dependencies.
package tssf_pkg;
  localparam int unsigned CoordBits    = 11;
  localparam int unsigned FractionBits = 8;
  localparam int unsigned RegBits      = 11;
  localparam int unsigned ScreenMax    = 1024;

  localparam logic CmdLoad = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic [0:0] RegWidth  = 1'b0;
  localparam logic [0:0] RegHeight = 1'b1;

  typedef enum logic [2:0] {
    StIdle, StLoad, StSetup, StDivide, StSpan, StOut
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic div_start;
    logic span;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic div_done;
  } stat_t;
endpackage

// File: hw/rtl/tssf_divider.sv
// Restoring divider, one quotient bit per cycle, two quotients side by side.
// No dependencies.
module tssf_divider #(
  parameter int unsigned NumBits = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [NumBits-1:0] num_a_i,
  input  logic [NumBits-1:0] den_a_i,
  input  logic [NumBits-1:0] num_b_i,
  input  logic [NumBits-1:0] den_b_i,
  output logic [NumBits-1:0] quo_a_o,
  output logic [NumBits-1:0] quo_b_o,
  output logic               done_o
);
  localparam int unsigned CntBits = $clog2(NumBits + 1);
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic [NumBits-1:0] ra_q, rb_q, qa_q, qb_q, da_q, db_q;
  logic [NumBits:0]   ta, tb;
  logic               run_q;

  assign ta = {ra_q, qa_q[NumBits-1]};
  assign tb = {rb_q, qb_q[NumBits-1]};
  assign cnt_d = cnt_q - CntBits'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= CntBits'(NumBits);
    end else if (run_q) begin
      cnt_q <= cnt_d;
      if (cnt_d == '0) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      ra_q <= '0; rb_q <= '0;
      qa_q <= num_a_i; qb_q <= num_b_i;
      da_q <= den_a_i; db_q <= den_b_i;
    end else if (run_q) begin
      if (ta >= {1'b0, da_q}) begin
        ra_q <= NumBits'(ta - {1'b0, da_q});
        qa_q <= {qa_q[NumBits-2:0], 1'b1};
      end else begin
        ra_q <= ta[NumBits-1:0];
        qa_q <= {qa_q[NumBits-2:0], 1'b0};
      end
      if (tb >= {1'b0, db_q}) begin
        rb_q <= NumBits'(tb - {1'b0, db_q});
        qb_q <= {qb_q[NumBits-2:0], 1'b1};
      end else begin
        rb_q <= tb[NumBits-1:0];
        qb_q <= {qb_q[NumBits-2:0], 1'b0};
      end
    end
  end

  assign quo_a_o = qa_q;
  assign quo_b_o = qb_q;
  assign done_o  = run_q && (cnt_q == CntBits'(1));
endmodule

// File: hw/rtl/tssf_datapath.sv
// Datapath: vertex store, sorting, ratio division, edge interpolation, clipping.
// Depends on tssf_pkg and tssf_divider.
module tssf_datapath #(
  parameter int unsigned CoordBits    = tssf_pkg::CoordBits,
  parameter int unsigned FractionBits = tssf_pkg::FractionBits
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  tssf_pkg::cmd_t            cmd_i,
  output tssf_pkg::stat_t           stat_o,
  input  logic [6*CoordBits+7:0]    load_i,
  input  logic [10:0]               width_i,
  input  logic [10:0]               height_i,
  output logic [9:0]                row_o,
  output logic [9:0]                start_o,
  output logic [9:0]                end_o,
  output logic [7:0]                color_o,
  output logic                      visible_o,
  output logic                      last_o
);
  import tssf_pkg::*;
  localparam int unsigned DB = CoordBits + 1;          // differences
  localparam int unsigned NB = DB + FractionBits;      // dividend width
  localparam int unsigned PB = DB + NB + 1;            // product width

  logic signed [CoordBits-1:0] x_q [3];
  logic signed [CoordBits-1:0] y_q [3];
  logic [7:0]  color_q;
  logic [DB-1:0] idx_q;
  logic busy_q;
  logic signed [CoordBits-1:0] ix [3], iy [3], sx1 [3], sy1 [3], sx2 [3], sy2 [3];
  logic signed [CoordBits-1:0] tx, ty;

  always_comb begin
    tx = '0;
    ty = '0;
    for (int k = 0; k < 3; k++) begin
      ix[k] = load_i[2*k*CoordBits +: CoordBits];
      iy[k] = load_i[(2*k+1)*CoordBits +: CoordBits];
    end
    sx1 = ix; sy1 = iy;
    if (sy1[0] > sy1[1]) begin
      tx = sx1[0]; sx1[0] = sx1[1]; sx1[1] = tx;
      ty = sy1[0]; sy1[0] = sy1[1]; sy1[1] = ty;
    end
    if (sy1[0] > sy1[2]) begin
      tx = sx1[0]; sx1[0] = sx1[2]; sx1[2] = tx;
      ty = sy1[0]; sy1[0] = sy1[2]; sy1[2] = ty;
    end
    sx2 = sx1; sy2 = sy1;
    if (sy2[1] > sy2[2]) begin
      tx = sx2[1]; sx2[1] = sx2[2]; sx2[2] = tx;
      ty = sy2[1]; sy2[1] = sy2[2]; sy2[2] = ty;
    end
  end

  // Edge setup values, registered before the divider starts.
  logic signed [DB-1:0] tot_q, seg_q, low_q;
  logic second_q, flat_q, last_q;
  logic signed [DB-1:0] total, seg, low;
  logic signed [DB-1:0] irow;
  logic sec;
  assign total = DB'(y_q[2]) - DB'(y_q[0]);
  assign seg   = DB'(y_q[1]) - DB'(y_q[0]);
  assign low   = DB'(y_q[2]) - DB'(y_q[1]);
  assign irow  = $signed(idx_q);
  assign sec   = (irow > seg) || (seg == '0);

  logic [NB-1:0] quo_a, quo_b;
  logic [NB-1:0] num_a;
  logic div_done;
  assign num_a = second_q ? NB'(unsigned'(irow - seg_q)) << FractionBits
                          : NB'(idx_q) << FractionBits;

  tssf_divider #(.NumBits(NB)) u_div (
    .clk_i, .rst_ni,
    .start_i (cmd_i.div_start),
    .num_a_i (num_a),
    .den_a_i (second_q ? NB'(unsigned'(low_q)) : NB'(unsigned'(seg_q))),
    .num_b_i (NB'(idx_q) << FractionBits),
    .den_b_i (NB'(unsigned'(tot_q))),
    .quo_a_o (quo_a),
    .quo_b_o (quo_b),
    .done_o  (div_done)
  );

  // Span computation: products then shift, clip.
  logic signed [PB-1:0] pa, pb;
  logic signed [DB-1:0] dxa, dxb, basea;
  logic signed [PB-1:0] sxw, exw, lo, hi, yrow, wc, hc;
  assign dxb   = DB'(x_q[2]) - DB'(x_q[0]);
  assign dxa   = second_q ? DB'(x_q[2]) - DB'(x_q[1]) : DB'(x_q[1]) - DB'(x_q[0]);
  assign basea = second_q ? DB'(x_q[1]) : DB'(x_q[0]);
  assign pa = PB'(dxa) * $signed({1'b0, quo_a});
  assign pb = PB'(dxb) * $signed({1'b0, quo_b});

  always_comb begin
    if (flat_q) begin
      sxw = PB'(x_q[0]);
      exw = PB'(x_q[1]);
    end else begin
      sxw = PB'(x_q[0]) + (pb >>> FractionBits);
      exw = PB'(basea) + (pa >>> FractionBits);
    end
    lo = (sxw > exw) ? exw : sxw;
    hi = (sxw > exw) ? sxw : exw;
    yrow = PB'(y_q[0]) + PB'(signed'({1'b0, idx_q}));
    wc = (width_i > 11'(ScreenMax)) ? PB'(ScreenMax) : PB'({1'b0, width_i});
    hc = (height_i > 11'(ScreenMax)) ? PB'(ScreenMax) : PB'({1'b0, height_i});
  end

  logic vis;
  assign vis = (yrow >= 0) && (yrow < hc) && (hi >= 0) && (lo < wc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        x_q[k] <= '0; y_q[k] <= '0;
      end
      color_q <= '0;
      idx_q   <= '0;
      busy_q  <= 1'b0;
    end else if (cmd_i.load) begin
      x_q <= sx2; y_q <= sy2;
      color_q <= load_i[6*CoordBits +: 8];
      idx_q <= '0;
      busy_q <= 1'b1;
    end else if (cmd_i.span) begin
      if (last_q) begin
        busy_q <= 1'b0;
        idx_q <= '0;
      end else begin
        idx_q <= idx_q + DB'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      tot_q <= total; seg_q <= seg; low_q <= low;
      second_q <= sec;
      flat_q <= (total == '0);
      last_q <= (total == '0) || (irow >= total);
    end
    if (cmd_i.span) begin
      row_o     <= vis ? yrow[9:0] : '0;
      start_o   <= vis ? ((lo < 0) ? '0 : lo[9:0]) : '0;
      end_o     <= vis ? ((hi > wc - 1) ? 10'(wc - 1) : hi[9:0]) : '0;
      color_o   <= color_q;
      visible_o <= vis;
      last_o    <= last_q;
    end
  end

  assign stat_o.busy     = busy_q;
  assign stat_o.div_done = div_done;

`ifndef ASSERT_OFF
  a_done_not_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> busy_q) else $error("divider finished without triangle");
  a_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |=> busy_q && idx_q == '0) else $error("load did not arm");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.span && last_q) |=> !busy_q) else $error("last row left busy");
`endif
endmodule

// File: hw/rtl/tssf_controller.sv
// Controller state machine: handshakes, sequencing of setup, divide and span.
// Depends on tssf_pkg.
module tssf_controller (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_cmd_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output tssf_pkg::cmd_t  cmd_o,
  input  tssf_pkg::stat_t stat_i
);
  import tssf_pkg::*;
  state_e state_q, state_d;
  logic   ov_q, ov_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (in_cmd_i == CmdLoad) cmd_o.load = 1'b1;
          else if (stat_i.busy) state_d = StSetup;
        end
      end
      StSetup: begin
        cmd_o.setup = 1'b1;
        state_d = StDivide;
      end
      StDivide: begin
        cmd_o.div_start = 1'b1;
        state_d = StLoad;
      end
      StLoad: if (stat_i.div_done) state_d = StSpan;
      StSpan: if (!ov_q || out_ready_i) begin
        cmd_o.span = 1'b1;
        ov_d = 1'b1;
        state_d = StIdle;
      end
      StOut: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign out_valid_o = ov_q;

`ifndef ASSERT_OFF
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.span && ov_q) |-> out_ready_i) else $error("result overwritten");
  a_span_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.span |=> ov_q) else $error("span not presented");
  a_tick_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.setup |-> stat_i.busy) else $error("tick on idle triangle");
`endif
endmodule

// File: hw/rtl/triangle_scanline_span_fill_core.sv
// Triangle span fill core: one request per tick gives one clipped span.
// A tick runs from acceptance through setup, divider start, a wait on the bit-serial
// divider that forms both edge ratios at once, and the span state that registers
// the span. A load is registered in the cycle it is accepted. One request is in
// work at a time; the result register lets the next request enter while a span
// waits. Async active-low reset.
module triangle_scanline_span_fill_core #(
  parameter int unsigned COORD_BITS    = tssf_pkg::CoordBits,
  parameter int unsigned FRACTION_BITS = tssf_pkg::FractionBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  input  logic s_axis_tuser_i,   // command
  // vert_a_x, vert_a_y, vert_b_x, vert_b_y, vert_c_x, vert_c_y, paint
  input  logic [((6*COORD_BITS+8+7)/8)*8-1:0] s_axis_tdata_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  output logic m_axis_tlast_o,   // last_row
  output logic m_axis_tuser_o,   // visible
  output logic [39:0] m_axis_tdata_o, // row, span_start, span_end, span_color
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import tssf_pkg::*;
  logic [10:0] width_q, height_q;
  cmd_t  cmd;
  stat_t stat;
  logic [9:0] row, sstart, send;
  logic [7:0] color;

  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd320;
      height_q <= 11'd200;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && paddr[2] == 1'b0) begin
      if (paddr[2] == RegWidth) width_q <= pwdata[10:0];
    end else if (psel && penable && pwrite && paddr == 3'd4) begin
      height_q <= pwdata[10:0];
    end
  end
  assign prdata = (paddr == 3'd0) ? {21'd0, width_q}
                : (paddr == 3'd4) ? {21'd0, height_q} : 32'd0;

  tssf_controller u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i (s_axis_tvalid_i),
    .in_cmd_i   (s_axis_tuser_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  tssf_datapath #(.CoordBits(COORD_BITS), .FractionBits(FRACTION_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i    (cmd),
    .stat_o   (stat),
    .load_i   (s_axis_tdata_i[6*COORD_BITS+7:0]),
    .width_i  (width_q),
    .height_i (height_q),
    .row_o    (row),
    .start_o  (sstart),
    .end_o    (send),
    .color_o  (color),
    .visible_o(m_axis_tuser_o),
    .last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {2'b00, color, send, sstart, row};
endmodule
